[design/llcp_pkg.sv]
package llcp_pkg;

  // coordinate differences, dot products and their products
  localparam int DIFF_W = 33;
  localparam int DOT_W  = 68;
  localparam int PROD_W = 2 * DOT_W;
  localparam int NUM_W  = PROD_W + 1;

  // final point arithmetic: 32 x 33 product, then add to a 32-bit point
  localparam int PP_W  = 32 + DIFF_W;
  localparam int SUM_W = PP_W + 1;

  // multiplier digit size and divider quotient bits below the saturation bit
  localparam int MUL_DIG = 16;
  localparam int QBITS   = 31;
  // prep stage, one cell per quotient bit, result stage
  localparam int DIV_LAT = QBITS + 2;

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_ctl_t;

  function automatic logic [31:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
      r = v[31:0];
    end else if (v[SUM_W-1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

endpackage

[design/llcp_dly.sv]
module llcp_dly #(
  parameter int W = 32,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < D; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[D-1];

endmodule

[design/llcp_mul.sv]
// Signed multiplier, one 16-bit digit of b per stage, lower digits unsigned,
// top digit signed. Needs at least two digits.
module llcp_mul #(
  parameter int WA = 68,
  parameter int WB = 68
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output logic signed [WA+WB-1:0] p
);
  import llcp_pkg::*;

  localparam int ND = (WB + MUL_DIG - 1) / MUL_DIG;
  localparam int BX = ND * MUL_DIG;
  localparam int PW = WA + WB;

  logic signed [WA-1:0] a_r   [ND-1];
  logic signed [BX-1:0] b_r   [ND-1];
  logic signed [PW-1:0] acc_r [ND];

  for (genvar i = 0; i < ND; i++) begin : g_stg
    logic signed [WA-1:0]        a_in;
    logic signed [BX-1:0]        b_in;
    logic signed [PW-1:0]        acc_in;
    logic signed [MUL_DIG:0]     dg;
    logic signed [WA+MUL_DIG:0]  pp;

    if (i == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BX'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[i-1];
      assign b_in   = b_r[i-1];
      assign acc_in = acc_r[i-1];
    end

    if (i == ND - 1) begin : g_top
      assign dg = {b_in[BX-1], b_in[BX-1 -: MUL_DIG]};
    end else begin : g_low
      assign dg = {1'b0, b_in[MUL_DIG*i +: MUL_DIG]};
    end

    assign pp = a_in * dg;

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i] <= acc_in + (PW'(pp) <<< (MUL_DIG * i));
      end
    end

    if (i < ND - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          a_r[i] <= a_in;
          b_r[i] <= b_in;
        end
      end
    end
  end

  assign p = acc_r[ND-1];

endmodule

[design/llcp_div_cell.sv]
// One restoring-division step: try the shifted divisor, keep one quotient bit.
module llcp_div_cell #(
  parameter int W = 64
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [W-1:0]              r_in,
  input  logic [W-1:0]              ds_in,
  input  logic [llcp_pkg::QBITS-1:0] q_in,
  input  llcp_pkg::div_ctl_t        ctl_in,
  output logic [W-1:0]              r_out,
  output logic [W-1:0]              ds_out,
  output logic [llcp_pkg::QBITS-1:0] q_out,
  output llcp_pkg::div_ctl_t        ctl_out
);
  import llcp_pkg::*;

  logic take;

  assign take = (r_in >= ds_in);

  always_ff @(posedge clk) begin
    if (en) begin
      r_out   <= take ? r_in - ds_in : r_in;
      ds_out  <= ds_in >> 1;
      q_out   <= {q_in[QBITS-2:0], take};
      ctl_out <= ctl_in;
    end
  end

endmodule

[design/llcp_div.sv]
// Signed / unsigned division truncated toward zero, saturated to 32 bits.
module llcp_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic [31:0]          quo
);
  import llcp_pkg::*;

  localparam int W = (NW > DW + QBITS) ? NW : DW + QBITS;

  logic signed [W-1:0] num_x;
  logic [W-1:0]        mag;
  logic [W-1:0]        den_x;

  logic [W-1:0]     r_c   [QBITS+1];
  logic [W-1:0]     ds_c  [QBITS+1];
  logic [QBITS-1:0] q_c   [QBITS+1];
  div_ctl_t         ctl_c [QBITS+1];

  logic [31:0] q_ext;

  assign num_x = W'(num);
  assign mag   = num[NW-1] ? W'(-num_x) : W'(num_x);
  assign den_x = W'(den);

  // quotient of 2^31 or more saturates whatever the sign
  always_ff @(posedge clk) begin
    if (en) begin
      r_c[0]       <= mag;
      ds_c[0]      <= den_x << (QBITS - 1);
      q_c[0]       <= '0;
      ctl_c[0].neg <= num[NW-1];
      ctl_c[0].ovf <= (mag >= (den_x << QBITS));
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    llcp_div_cell #(.W(W)) u_cell (
      .clk     (clk),
      .en      (en),
      .r_in    (r_c[i]),
      .ds_in   (ds_c[i]),
      .q_in    (q_c[i]),
      .ctl_in  (ctl_c[i]),
      .r_out   (r_c[i+1]),
      .ds_out  (ds_c[i+1]),
      .q_out   (q_c[i+1]),
      .ctl_out (ctl_c[i+1])
    );
  end

  assign q_ext = {1'b0, q_c[QBITS]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_c[QBITS].ovf) begin
        quo <= ctl_c[QBITS].neg ? SAT_MIN : SAT_MAX;
      end else begin
        quo <= ctl_c[QBITS].neg ? 32'd0 - q_ext : q_ext;
      end
    end
  end

endmodule

[design/line_line_closest_points_3d_core.sv]
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------------
// input   | in_valid / in_stall  | p1..p4 x/y/z, signed fixed point
// output  | out_valid / out_stall| pa, pb x/y/z, param_a, param_b, degenerate
//
// One transfer per cycle in each direction while the output is not stalled;
// the pipeline depth is set by the two 31-cell restoring dividers and the digit
// multipliers. Reset clears only the stage valid bits. A stalled output
// freezes the whole pipeline and stalls the input in the same cycle.
module line_line_closest_points_3d_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p1_z,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] p2_z,
  input  logic signed [31:0] p3_x,
  input  logic signed [31:0] p3_y,
  input  logic signed [31:0] p3_z,
  input  logic signed [31:0] p4_x,
  input  logic signed [31:0] p4_y,
  input  logic signed [31:0] p4_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pa_x,
  output logic signed [31:0] pa_y,
  output logic signed [31:0] pa_z,
  output logic signed [31:0] pb_x,
  output logic signed [31:0] pb_y,
  output logic signed [31:0] pb_z,
  output logic signed [31:0] param_a,
  output logic signed [31:0] param_b,
  output logic               degenerate
);
  import llcp_pkg::*;

  localparam int M1L    = (DOT_W + MUL_DIG - 1) / MUL_DIG;
  localparam int M2L    = (32 + MUL_DIG - 1) / MUL_DIG;
  localparam int N1_W   = NUM_W + FRAC_BITS;
  localparam int PR2_W  = DOT_W + 32;
  localparam int MW_W   = ((DOT_W + FRAC_BITS > PR2_W) ? DOT_W + FRAC_BITS : PR2_W) + 1;

  // stage at which each value sits in a register
  localparam int ST_DOT = 3;
  localparam int ST_M1  = ST_DOT + M1L;
  localparam int ST_DEN = ST_M1 + 1;
  localparam int ST_MUA = ST_DEN + DIV_LAT;
  localparam int ST_M2  = ST_MUA + M2L;
  localparam int ST_MW  = ST_M2 + 1;
  localparam int ST_MUB = ST_MW + DIV_LAT;
  localparam int ST_PP  = ST_MUB + 1;

  logic advance;
  logic [ST_PP-1:0] vld;

  logic signed [31:0] pin1 [3], pin2 [3], pin3 [3], pin4 [3];

  logic signed [31:0]       p1_r  [3], p3_r [3];
  logic signed [DIFF_W-1:0] d13_r [3], d43_r [3], d21_r [3];

  logic signed [2*DIFF_W-1:0] m1343 [3], m4321 [3], m1321 [3], m4343 [3], m2121 [3];

  logic signed [DOT_W-1:0] d1343, d4321, d1321, d4343, d2121;

  logic signed [PROD_W-1:0] pr_2121_4343, pr_4321_4321, pr_1343_4321, pr_1321_4343;

  logic signed [NUM_W-1:0] denom, numer;
  logic                    deg_den;

  logic [31:0]             mua;
  logic signed [DOT_W-1:0] d4321_d, d1343_d, d4343_d;
  logic signed [PR2_W-1:0] pr2;
  logic signed [MW_W-1:0]  mw;
  logic [31:0]             mub;
  logic [31:0]             mua_d;
  logic                    deg_d;

  logic signed [31:0]       p1_d  [3], p3_d [3];
  logic signed [DIFF_W-1:0] d21_d [3], d43_d [3];

  logic signed [PP_W-1:0] ta [3], tb [3];
  logic signed [31:0]     p1_pp [3], p3_pp [3];
  logic [31:0]            mua_pp, mub_pp;
  logic                   deg_pp;

  logic [31:0] pa_n [3], pb_n [3];

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    pin1[0] = p1_x; pin1[1] = p1_y; pin1[2] = p1_z;
    pin2[0] = p2_x; pin2[1] = p2_y; pin2[2] = p2_z;
    pin3[0] = p3_x; pin3[1] = p3_y; pin3[2] = p3_z;
    pin4[0] = p4_x; pin4[1] = p4_y; pin4[2] = p4_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      vld       <= {vld[ST_PP-2:0], in_valid};
      out_valid <= vld[ST_PP-1];
    end
  end

  // differences, products, dot products
  for (genvar k = 0; k < 3; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (advance) begin
        p1_r[k]  <= pin1[k];
        p3_r[k]  <= pin3[k];
        d13_r[k] <= DIFF_W'(pin1[k]) - DIFF_W'(pin3[k]);
        d43_r[k] <= DIFF_W'(pin4[k]) - DIFF_W'(pin3[k]);
        d21_r[k] <= DIFF_W'(pin2[k]) - DIFF_W'(pin1[k]);
        m1343[k] <= d13_r[k] * d43_r[k];
        m4321[k] <= d43_r[k] * d21_r[k];
        m1321[k] <= d13_r[k] * d21_r[k];
        m4343[k] <= d43_r[k] * d43_r[k];
        m2121[k] <= d21_r[k] * d21_r[k];
      end
    end

    llcp_dly #(.W(32), .D(ST_MUB - 1)) u_dly_p1 (
      .clk(clk), .en(advance), .d(p1_r[k]), .q(p1_d[k]));
    llcp_dly #(.W(32), .D(ST_MUB - 1)) u_dly_p3 (
      .clk(clk), .en(advance), .d(p3_r[k]), .q(p3_d[k]));
    llcp_dly #(.W(DIFF_W), .D(ST_MUB - 1)) u_dly_d21 (
      .clk(clk), .en(advance), .d(d21_r[k]), .q(d21_d[k]));
    llcp_dly #(.W(DIFF_W), .D(ST_MUB - 1)) u_dly_d43 (
      .clk(clk), .en(advance), .d(d43_r[k]), .q(d43_d[k]));

    always_ff @(posedge clk) begin
      if (advance) begin
        ta[k]    <= signed'(mua_d) * d21_d[k];
        tb[k]    <= signed'(mub) * d43_d[k];
        p1_pp[k] <= p1_d[k];
        p3_pp[k] <= p3_d[k];
      end
    end

    assign pa_n[k] = sat_sum(SUM_W'(p1_pp[k]) + SUM_W'(ta[k] >>> FRAC_BITS));
    assign pb_n[k] = sat_sum(SUM_W'(p3_pp[k]) + SUM_W'(tb[k] >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d1343 <= DOT_W'(m1343[0]) + DOT_W'(m1343[1]) + DOT_W'(m1343[2]);
      d4321 <= DOT_W'(m4321[0]) + DOT_W'(m4321[1]) + DOT_W'(m4321[2]);
      d1321 <= DOT_W'(m1321[0]) + DOT_W'(m1321[1]) + DOT_W'(m1321[2]);
      d4343 <= DOT_W'(m4343[0]) + DOT_W'(m4343[1]) + DOT_W'(m4343[2]);
      d2121 <= DOT_W'(m2121[0]) + DOT_W'(m2121[1]) + DOT_W'(m2121[2]);
    end
  end

  llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_a (
    .clk(clk), .en(advance), .a(d2121), .b(d4343), .p(pr_2121_4343));
  llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_b (
    .clk(clk), .en(advance), .a(d4321), .b(d4321), .p(pr_4321_4321));
  llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_c (
    .clk(clk), .en(advance), .a(d1343), .b(d4321), .p(pr_1343_4321));
  llcp_mul #(.WA(DOT_W), .WB(DOT_W)) u_mul_d (
    .clk(clk), .en(advance), .a(d1321), .b(d4343), .p(pr_1321_4343));

  // denom never goes negative
  always_ff @(posedge clk) begin
    if (advance) begin
      denom   <= NUM_W'(pr_2121_4343) - NUM_W'(pr_4321_4321);
      numer   <= NUM_W'(pr_1343_4321) - NUM_W'(pr_1321_4343);
      deg_den <= (pr_2121_4343 == pr_4321_4321);
    end
  end

  llcp_div #(.NW(N1_W), .DW(NUM_W - 1)) u_div_a (
    .clk (clk),
    .en  (advance),
    .num (N1_W'(numer) <<< FRAC_BITS),
    .den (denom[NUM_W-2:0]),
    .quo (mua)
  );

  llcp_dly #(.W(DOT_W), .D(ST_MUA - ST_DOT)) u_dly_4321 (
    .clk(clk), .en(advance), .d(d4321), .q(d4321_d));
  llcp_dly #(.W(DOT_W), .D(ST_M2 - ST_DOT)) u_dly_1343 (
    .clk(clk), .en(advance), .d(d1343), .q(d1343_d));
  llcp_dly #(.W(DOT_W), .D(ST_MW - ST_DOT)) u_dly_4343 (
    .clk(clk), .en(advance), .d(d4343), .q(d4343_d));

  llcp_mul #(.WA(DOT_W), .WB(32)) u_mul_e (
    .clk(clk), .en(advance), .a(d4321_d), .b(signed'(mua)), .p(pr2));

  always_ff @(posedge clk) begin
    if (advance) begin
      mw <= (MW_W'(d1343_d) <<< FRAC_BITS) + MW_W'(pr2);
    end
  end

  llcp_div #(.NW(MW_W), .DW(DOT_W - 2)) u_div_b (
    .clk (clk),
    .en  (advance),
    .num (mw),
    .den (d4343_d[DOT_W-3:0]),
    .quo (mub)
  );

  llcp_dly #(.W(32), .D(ST_MUB - ST_MUA)) u_dly_mua (
    .clk(clk), .en(advance), .d(mua), .q(mua_d));
  llcp_dly #(.W(1), .D(ST_MUB - ST_DEN)) u_dly_deg (
    .clk(clk), .en(advance), .d(deg_den), .q(deg_d));

  always_ff @(posedge clk) begin
    if (advance) begin
      mua_pp <= mua_d;
      mub_pp <= mub;
      deg_pp <= deg_d;
    end
  end

  // output register; degenerate pairs give zeros
  always_ff @(posedge clk) begin
    if (advance) begin
      degenerate <= deg_pp;
      pa_x    <= deg_pp ? '0 : pa_n[0];
      pa_y    <= deg_pp ? '0 : pa_n[1];
      pa_z    <= deg_pp ? '0 : pa_n[2];
      pb_x    <= deg_pp ? '0 : pb_n[0];
      pb_y    <= deg_pp ? '0 : pb_n[1];
      pb_z    <= deg_pp ? '0 : pb_n[2];
      param_a <= deg_pp ? '0 : mua_pp;
      param_b <= deg_pp ? '0 : mub_pp;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> pa_x == 0 && pa_y == 0 && pa_z == 0 &&
      pb_x == 0 && pb_y == 0 && pb_z == 0 && param_a == 0 && param_b == 0)
    else $error("degenerate result carries nonzero fields");

  a_take_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld) && out_valid)
    else $error("pipeline moved while stalled");

endmodule

[test/line_line_closest_points_3d_core_tb.sv]
typedef logic signed [191:0] wide_t;

typedef struct {
  logic signed [31:0] p1[3];
  logic signed [31:0] p2[3];
  logic signed [31:0] p3[3];
  logic signed [31:0] p4[3];
} line_pair_t;

typedef struct {
  logic signed [31:0] pa[3];
  logic signed [31:0] pb[3];
  logic signed [31:0] mua;
  logic signed [31:0] mub;
  logic               degenerate;
} closest_pts_t;

class closest_point_sb;
  localparam int FRAC = 16;
  closest_pts_t pending_results[$];
  int mismatches = 0;

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -wide_t'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic closest_pts_t closest_points(line_pair_t lp);
    closest_pts_t r;
    wide_t d13[3], d43[3], d21[3];
    wide_t d1343, d4321, d1321, d4343, d2121, denom, numer, mua_w, mub_w;
    d1343 = 0; d4321 = 0; d1321 = 0; d4343 = 0; d2121 = 0;
    for (int k = 0; k < 3; k++) begin
      d13[k] = wide_t'(lp.p1[k]) - wide_t'(lp.p3[k]);
      d43[k] = wide_t'(lp.p4[k]) - wide_t'(lp.p3[k]);
      d21[k] = wide_t'(lp.p2[k]) - wide_t'(lp.p1[k]);
      d1343 += d13[k] * d43[k];
      d4321 += d43[k] * d21[k];
      d1321 += d13[k] * d21[k];
      d4343 += d43[k] * d43[k];
      d2121 += d21[k] * d21[k];
    end
    denom = d2121 * d4343 - d4321 * d4321;
    numer = d1343 * d4321 - d1321 * d4343;
    if (denom == 0 || d4343 == 0) begin
      for (int k = 0; k < 3; k++) begin
        r.pa[k] = '0;
        r.pb[k] = '0;
      end
      r.mua = '0;
      r.mub = '0;
      r.degenerate = 1'b1;
      return r;
    end
    // division truncates toward zero, as in the datapath
    r.mua = sat32((numer <<< FRAC) / denom);
    mua_w = wide_t'(r.mua);
    r.mub = sat32(((d1343 <<< FRAC) + d4321 * mua_w) / d4343);
    mub_w = wide_t'(r.mub);
    for (int k = 0; k < 3; k++) begin
      r.pa[k] = sat32(wide_t'(lp.p1[k]) + ((mua_w * d21[k]) >>> FRAC));
      r.pb[k] = sat32(wide_t'(lp.p3[k]) + ((mub_w * d43[k]) >>> FRAC));
    end
    r.degenerate = 1'b0;
    return r;
  endfunction

  function void note_pair(line_pair_t lp);
    pending_results.push_back(closest_points(lp));
  endfunction

  function void check_result(closest_pts_t got);
    closest_pts_t exp_r;
    bit bad;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      return;
    end
    exp_r = pending_results.pop_front();
    bad = (got.mua !== exp_r.mua) || (got.mub !== exp_r.mub)
       || (got.degenerate !== exp_r.degenerate);
    for (int k = 0; k < 3; k++)
      if (got.pa[k] !== exp_r.pa[k] || got.pb[k] !== exp_r.pb[k]) bad = 1;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: exp pa %h %h %h pb %h %h %h mua %h mub %h deg %b",
                 $realtime, exp_r.pa[0], exp_r.pa[1], exp_r.pa[2], exp_r.pb[0],
                 exp_r.pb[1], exp_r.pb[2], exp_r.mua, exp_r.mub, exp_r.degenerate,
                 "\n    got pa %h %h %h pb %h %h %h mua %h mub %h deg %b",
                 got.pa[0], got.pa[1], got.pa[2], got.pb[0], got.pb[1], got.pb[2],
                 got.mua, got.mub, got.degenerate);
    end
  endfunction
endclass

module line_line_closest_points_3d_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] p1_x = 0, p1_y = 0, p1_z = 0, p2_x = 0, p2_y = 0, p2_z = 0;
  logic signed [31:0] p3_x = 0, p3_y = 0, p3_z = 0, p4_x = 0, p4_y = 0, p4_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z, param_a, param_b;
  logic degenerate;

  int idle_pct = 0;
  int stall_pct = 0;
  closest_point_sb sb = new();

  line_line_closest_points_3d_core DUT (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #1ms;
    $display("line_line_closest_points_3d_core regression: fail");
    $finish;
  end

  // result side: random stall, check every transfer
  always @(posedge clk) begin
    closest_pts_t got;
    if (!rst && out_valid && !out_stall) begin
      got.pa[0] = pa_x; got.pa[1] = pa_y; got.pa[2] = pa_z;
      got.pb[0] = pb_x; got.pb[1] = pb_y; got.pb[2] = pb_z;
      got.mua = param_a; got.mub = param_b; got.degenerate = degenerate;
      sb.check_result(got);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_pair(line_pair_t lp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {p1_x, p1_y, p1_z} <= {lp.p1[0], lp.p1[1], lp.p1[2]};
    {p2_x, p2_y, p2_z} <= {lp.p2[0], lp.p2[1], lp.p2[2]};
    {p3_x, p3_y, p3_z} <= {lp.p3[0], lp.p3[1], lp.p3[2]};
    {p4_x, p4_y, p4_z} <= {lp.p4[0], lp.p4[1], lp.p4[2]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pair(lp);
  endtask

  function automatic logic signed [31:0] rnd_coord(int bits);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (32 - bits);
  endfunction

  task automatic send_vec(logic signed [31:0] a[3], logic signed [31:0] b[3],
                          logic signed [31:0] c[3], logic signed [31:0] d[3]);
    line_pair_t lp;
    lp.p1 = a; lp.p2 = b; lp.p3 = c; lp.p4 = d;
    send_pair(lp);
  endtask

  localparam logic signed [31:0] MX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  task automatic random_pair();
    line_pair_t lp;
    int mode, bits, s;
    mode = $urandom_range(99);
    bits = (mode < 50) ? $urandom_range(24, 8) : 32;
    for (int k = 0; k < 3; k++) begin
      lp.p1[k] = rnd_coord(bits);
      lp.p2[k] = rnd_coord(bits);
      lp.p3[k] = rnd_coord(bits);
      lp.p4[k] = rnd_coord(bits);
    end
    s = $urandom_range(4, 1);
    if (mode >= 70 && mode < 82) begin
      // nearly parallel: big parameters, saturation likely
      bits = $urandom_range(20, 12);
      for (int k = 0; k < 3; k++) begin
        lp.p1[k] = rnd_coord(bits); lp.p2[k] = rnd_coord(bits);
        lp.p3[k] = rnd_coord(bits);
        lp.p4[k] = lp.p3[k] + lp.p2[k] - lp.p1[k] + rnd_coord(3);
      end
    end else if (mode >= 82 && mode < 90) begin
      // exactly parallel
      for (int k = 0; k < 3; k++) begin
        lp.p1[k] = rnd_coord(20); lp.p2[k] = rnd_coord(20); lp.p3[k] = rnd_coord(20);
        lp.p4[k] = lp.p3[k] + s * (lp.p2[k] - lp.p1[k]);
      end
    end else if (mode >= 90 && mode < 95) begin
      lp.p2 = lp.p1;
    end else if (mode >= 95) begin
      lp.p4 = lp.p3;
    end
    send_pair(lp);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zeros, extremes, skew/parallel/zero-length cases
    send_vec('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
    send_vec('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, ONE}, '{0, 2*ONE, ONE});
    send_vec('{0, 0, 0}, '{ONE, ONE, 0}, '{0, ONE, -ONE}, '{ONE, 0, -ONE});
    send_vec('{ONE, 0, 0}, '{2*ONE, 0, 0}, '{0, ONE, 0}, '{0, 2*ONE, 0});
    send_vec('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{3*ONE, ONE, 0});
    send_vec('{5, 6, 7}, '{5, 6, 7}, '{0, 0, 0}, '{ONE, ONE, ONE});
    send_vec('{0, 0, 0}, '{ONE, ONE, ONE}, '{9, 9, 9}, '{9, 9, 9});
    send_vec('{MN, MN, MN}, '{MX, MX, MX}, '{MX, MN, MX}, '{MN, MX, MN});
    send_vec('{MX, MX, MX}, '{MN, MN, MN}, '{MN, MX, 0}, '{MX, MN, 0});
    send_vec('{MN, 0, MX}, '{MX, 0, MN}, '{0, MN, 0}, '{0, MX, 1});
    send_vec('{MX, MX, 0}, '{MN, MN, 1}, '{MX, MN, MX}, '{MN, MX, MN + 1});
    send_vec('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1});
    send_vec('{0, 0, 0}, '{ONE, 0, 0}, '{0, ONE, 0}, '{ONE, ONE, 1});
    send_vec('{0, 0, 0}, '{1, 0, 0}, '{0, MX, MN}, '{MX, MX, MN});
    send_vec('{-ONE, -ONE, -ONE}, '{ONE, ONE, ONE}, '{ONE, -ONE, 0}, '{-ONE, ONE, 0});

    idle_pct = 6; stall_pct = 77;
    repeat (230) random_pair();
    idle_pct = 77; stall_pct = 6;
    repeat (230) random_pair();
    idle_pct = 0; stall_pct = 0;
    repeat (230) random_pair();
    in_valid <= 0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("line_line_closest_points_3d_core regression: pass");
    end else begin
      $display("line_line_closest_points_3d_core regression: fail");
    end
    $finish;
  end
endmodule

[line_line_closest_points_3d_core.f]
design/llcp_pkg.sv
design/llcp_dly.sv
design/llcp_mul.sv
design/llcp_div_cell.sv
design/llcp_div.sv
design/line_line_closest_points_3d_core.sv
test/line_line_closest_points_3d_core_tb.sv
